[rtl/core/dq_pkg.sv]
// Package for the double-ended queue: depth, widths, request and result types.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package dq_pkg;

  localparam int DQ_DEPTH = 16;
  localparam int DQ_CNT_W = $clog2(DQ_DEPTH + 1);
  localparam int DQ_DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_SHR  = 2'd2,
    CELL_SHL  = 2'd3
  } cell_op_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [DQ_DATA_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic signed [DQ_DATA_W-1:0]  front_value;
    logic signed [DQ_DATA_W-1:0]  back_value;
    logic [DQ_CNT_W-1:0]          fill_count;
    status_t                      status;
  } out_req_t;

  typedef struct packed {
    logic                         shr;
    logic                         shl;
    logic                         wr;
    logic [DQ_CNT_W-1:0]          pos;
    logic signed [DQ_DATA_W-1:0]  data;
  } chain_ctl_t;

endpackage

`default_nettype wire

[rtl/core/dq_cell.sv]
// One storage cell of the queue chain: hold, load, or take a neighbour's value.
// Depends on dq_pkg.
`default_nettype none

module dq_cell
  import dq_pkg::*;
(
  input  wire logic                        clk,
  input  wire cell_op_t                    op,
  input  wire logic signed [DQ_DATA_W-1:0] left_data,
  input  wire logic signed [DQ_DATA_W-1:0] right_data,
  input  wire logic signed [DQ_DATA_W-1:0] load_data,
  output      logic signed [DQ_DATA_W-1:0] data_r
);

  logic signed [DQ_DATA_W-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_LOAD: data_nxt = load_data;
      CELL_SHR:  data_nxt = left_data;
      CELL_SHL:  data_nxt = right_data;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/dq_chain.sv]
// Row of DQ_DEPTH cells ordered from one end of the queue; cell 0 is that end.
// Depends on dq_pkg and dq_cell.
`default_nettype none

module dq_chain
  import dq_pkg::*;
(
  input  wire logic                        clk,
  input  wire chain_ctl_t                  ctl,
  output      logic signed [DQ_DATA_W-1:0] head0,
  output      logic signed [DQ_DATA_W-1:0] head1
);

  logic signed [DQ_DATA_W-1:0] cell_q [DQ_DEPTH];
  cell_op_t                    cell_op [DQ_DEPTH];

  for (genvar i = 0; i < DQ_DEPTH; i++) begin : g_cell
    logic signed [DQ_DATA_W-1:0] left_d;
    logic signed [DQ_DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = ctl.data;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    if (i == DQ_DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    always_comb begin
      if (ctl.shr) begin
        cell_op[i] = CELL_SHR;
      end else if (ctl.shl) begin
        cell_op[i] = CELL_SHL;
      end else if (ctl.wr && (ctl.pos == DQ_CNT_W'(i))) begin
        cell_op[i] = CELL_LOAD;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    dq_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .left_data  (left_d),
      .right_data (right_d),
      .load_data  (ctl.data),
      .data_r     (cell_q[i])
    );
  end

  assign head0 = cell_q[0];
  assign head1 = cell_q[1];

endmodule

`default_nettype wire

[rtl/core/double_ended_queue.sv]
// Top level of the double-ended queue: two mirrored cell chains, fill count, result register.
// Depends on dq_pkg and dq_chain.
//
// A deque of 16 signed 32-bit values. Every request (push or pop at either end) is
// answered by one result carrying the front and back values, the fill count and a
// status. The values live twice, in a chain ordered front-first and one ordered
// back-first, so both ends sit in cell 0 of a chain and each request is at most a single
// shift or a single write per chain. A request is accepted whenever the result register
// is empty or its result is being taken in the same cycle, so back-to-back requests
// run at one per cycle while results are taken, and the result is registered and
// appears in the cycle after acceptance.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire in_req_t  in_req,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      out_req_t out_req
);

  logic                        accept;
  logic                        full;
  logic                        empty;
  logic                        many;
  logic [DQ_CNT_W-1:0]         count_r;
  logic [DQ_CNT_W-1:0]         count_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  out_req_t                    out_r;
  out_req_t                    res;
  chain_ctl_t                  ctl_a;
  chain_ctl_t                  ctl_b;
  logic signed [DQ_DATA_W-1:0] a_head0;
  logic signed [DQ_DATA_W-1:0] a_head1;
  logic signed [DQ_DATA_W-1:0] b_head0;
  logic signed [DQ_DATA_W-1:0] b_head1;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == DQ_CNT_W'(DQ_DEPTH));
  assign empty     = (count_r == '0);
  assign many      = (count_r > DQ_CNT_W'(1));
  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  always_comb begin
    ctl_a           = '0;
    ctl_b           = '0;
    ctl_a.pos       = count_r;
    ctl_b.pos       = count_r;
    ctl_a.data      = in_req.value;
    ctl_b.data      = in_req.value;
    count_nxt       = count_r;
    res.status      = STAT_OK;
    res.front_value = a_head0;
    res.back_value  = b_head0;
    case (in_req.kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          ctl_a.shr       = 1'b1;
          ctl_b.wr        = 1'b1;
          count_nxt       = count_r + DQ_CNT_W'(1);
          res.front_value = in_req.value;
          res.back_value  = empty ? in_req.value : b_head0;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          ctl_a.wr        = 1'b1;
          ctl_b.shr       = 1'b1;
          count_nxt       = count_r + DQ_CNT_W'(1);
          res.front_value = empty ? in_req.value : a_head0;
          res.back_value  = in_req.value;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          res.status      = STAT_EMPTY;
          res.front_value = '0;
          res.back_value  = '0;
        end else begin
          ctl_a.shl       = 1'b1;
          count_nxt       = count_r - DQ_CNT_W'(1);
          res.front_value = many ? a_head1 : '0;
          res.back_value  = many ? b_head0 : '0;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          res.status      = STAT_EMPTY;
          res.front_value = '0;
          res.back_value  = '0;
        end else begin
          ctl_b.shl       = 1'b1;
          count_nxt       = count_r - DQ_CNT_W'(1);
          res.front_value = many ? a_head0 : '0;
          res.back_value  = many ? b_head1 : '0;
        end
      end
      default: begin
        res.status = STAT_OK;
      end
    endcase
    res.fill_count = count_nxt;
    if (!accept) begin
      ctl_a.shr = 1'b0;
      ctl_a.shl = 1'b0;
      ctl_a.wr  = 1'b0;
      ctl_b.shr = 1'b0;
      ctl_b.shl = 1'b0;
      ctl_b.wr  = 1'b0;
    end
    out_valid_nxt = accept || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  dq_chain u_chain_front (
    .clk   (clk),
    .ctl   (ctl_a),
    .head0 (a_head0),
    .head1 (a_head1)
  );

  dq_chain u_chain_back (
    .clk   (clk),
    .ctl   (ctl_b),
    .head0 (b_head0),
    .head1 (b_head1)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DQ_CNT_W'(DQ_DEPTH))
    else $error("fill count beyond depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && empty && (in_req.kind == KIND_POP_FRONT || in_req.kind == KIND_POP_BACK)
    |=> out_r.status == STAT_EMPTY)
    else $error("pop on empty not flagged");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fill_count == '0 |-> out_r.front_value == '0 && out_r.back_value == '0)
    else $error("empty queue result carries data");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.fill_count == count_r)
    else $error("result count differs from held count");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request gave no result");
`endif

endmodule

`default_nettype wire
